// ----- src/crth_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crth_pkg
// shared types, constants and the multiply-accumulate program of the
// nearest ray/triangle hit core
// ----------------------------------------------------------------------------
package crth_pkg;

  localparam int MAX_SURFACES  = 4096;
  localparam int MAX_TRIANGLES = 65536;

  localparam logic [30:0] DIST_MAX = '1;

  // wide working widths
  localparam int AW  = 68;   // multiplicand, holds the q vector
  localparam int BW  = 40;   // multiplier, five 8-bit digits
  localparam int ACW = 104;  // accumulator, holds tn
  localparam int DVW = 120;  // divider remainder and shifted divisor

  typedef struct packed {
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_z;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;
    logic [11:0]        surface_id;
    logic [15:0]        triangle_id;
    logic               last_triangle;
  } tri_t;

  typedef struct packed {
    logic               hit_found;
    logic [30:0]        hit_distance;
    logic [11:0]        hit_surface;
    logic [15:0]        hit_triangle;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } res_t;

  typedef struct packed {
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_origin_z;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic signed [15:0] ray_dir_z;
    logic [31:0]        det_threshold;
    logic [30:0]        min_distance;
  } cfg_t;

  typedef struct packed {
    tri_t item;
    logic skip;
  } entry_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
    REG_DIR_X, REG_DIR_Y, REG_DIR_Z,
    REG_DET_THRESHOLD, REG_MIN_DISTANCE
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MAC, S_NORM, S_TEST, S_DIV, S_UPDATE, S_HIT, S_EMIT
  } back_state_t;

  typedef enum logic [3:0] {
    A_E2X, A_E2Y, A_E2Z, A_TX, A_TY, A_TZ,
    A_PX, A_PY, A_PZ, A_QX, A_QY, A_QZ, A_DIST
  } a_sel_t;

  typedef enum logic [3:0] {
    B_DX, B_DY, B_DZ, B_E1X, B_E1Y, B_E1Z,
    B_TX, B_TY, B_TZ, B_E2X, B_E2Y, B_E2Z
  } b_sel_t;

  typedef enum logic [3:0] {
    D_PX, D_PY, D_PZ, D_QX, D_QY, D_QZ,
    D_DET, D_UN, D_VN, D_TN, D_HX, D_HY, D_HZ
  } dest_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    logic   neg;
    logic   first;
    logic   last;
    dest_t  dest;
  } mac_op_t;

  localparam logic [4:0] OP_TEST_LAST = 5'd23;
  localparam logic [4:0] OP_HIT_FIRST = 5'd24;
  localparam logic [4:0] OP_HIT_LAST  = 5'd26;

  function automatic mac_op_t mac_op(input logic [4:0] idx);
    mac_op_t r;
    unique case (idx)
      5'd0:    r = '{A_E2Z, B_DY,  1'b0, 1'b1, 1'b0, D_PX};
      5'd1:    r = '{A_E2Y, B_DZ,  1'b1, 1'b0, 1'b1, D_PX};
      5'd2:    r = '{A_E2X, B_DZ,  1'b0, 1'b1, 1'b0, D_PY};
      5'd3:    r = '{A_E2Z, B_DX,  1'b1, 1'b0, 1'b1, D_PY};
      5'd4:    r = '{A_E2Y, B_DX,  1'b0, 1'b1, 1'b0, D_PZ};
      5'd5:    r = '{A_E2X, B_DY,  1'b1, 1'b0, 1'b1, D_PZ};
      5'd6:    r = '{A_TY,  B_E1Z, 1'b0, 1'b1, 1'b0, D_QX};
      5'd7:    r = '{A_TZ,  B_E1Y, 1'b1, 1'b0, 1'b1, D_QX};
      5'd8:    r = '{A_TZ,  B_E1X, 1'b0, 1'b1, 1'b0, D_QY};
      5'd9:    r = '{A_TX,  B_E1Z, 1'b1, 1'b0, 1'b1, D_QY};
      5'd10:   r = '{A_TX,  B_E1Y, 1'b0, 1'b1, 1'b0, D_QZ};
      5'd11:   r = '{A_TY,  B_E1X, 1'b1, 1'b0, 1'b1, D_QZ};
      5'd12:   r = '{A_PX,  B_E1X, 1'b0, 1'b1, 1'b0, D_DET};
      5'd13:   r = '{A_PY,  B_E1Y, 1'b0, 1'b0, 1'b0, D_DET};
      5'd14:   r = '{A_PZ,  B_E1Z, 1'b0, 1'b0, 1'b1, D_DET};
      5'd15:   r = '{A_PX,  B_TX,  1'b0, 1'b1, 1'b0, D_UN};
      5'd16:   r = '{A_PY,  B_TY,  1'b0, 1'b0, 1'b0, D_UN};
      5'd17:   r = '{A_PZ,  B_TZ,  1'b0, 1'b0, 1'b1, D_UN};
      5'd18:   r = '{A_QX,  B_DX,  1'b0, 1'b1, 1'b0, D_VN};
      5'd19:   r = '{A_QY,  B_DY,  1'b0, 1'b0, 1'b0, D_VN};
      5'd20:   r = '{A_QZ,  B_DZ,  1'b0, 1'b0, 1'b1, D_VN};
      5'd21:   r = '{A_QX,  B_E2X, 1'b0, 1'b1, 1'b0, D_TN};
      5'd22:   r = '{A_QY,  B_E2Y, 1'b0, 1'b0, 1'b0, D_TN};
      5'd23:   r = '{A_QZ,  B_E2Z, 1'b0, 1'b0, 1'b1, D_TN};
      5'd24:   r = '{A_DIST, B_DX, 1'b0, 1'b1, 1'b1, D_HX};
      5'd25:   r = '{A_DIST, B_DY, 1'b0, 1'b1, 1'b1, D_HY};
      5'd26:   r = '{A_DIST, B_DZ, 1'b0, 1'b1, 1'b1, D_HZ};
      default: r = '{A_DIST, B_DX, 1'b0, 1'b1, 1'b1, D_HX};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/crth_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crth_queue
// two-entry queue between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
module crth_queue
  import crth_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/crth_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crth_front
// accepts triangle transactions, flags out-of-range tags, feeds the queue
// ----------------------------------------------------------------------------
module crth_front
  import crth_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   tri_valid,
  output logic   tri_stall,
  input  tri_t   tri_data,
  output logic   push,
  output entry_t push_data,
  input  logic   q_full
);

  logic   slot_valid;
  entry_t slot;
  logic   take;

  assign push      = slot_valid && !q_full;
  assign push_data = slot;
  assign tri_stall = slot_valid && q_full;
  assign take      = tri_valid && !tri_stall;

  always_ff @(posedge clk) begin
    if (take) begin
      slot.item <= tri_data;
      slot.skip <= (32'(tri_data.surface_id) >= MAX_SURFACES) ||
                   (32'(tri_data.triangle_id) >= MAX_TRIANGLES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (take) begin
      slot_valid <= 1'b1;
    end else if (push) begin
      slot_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- src/crth_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crth_back
// intersection test on a shared multiply-accumulate unit, restoring divider,
// running nearest hit and the result register
// ----------------------------------------------------------------------------
module crth_back
  import crth_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   q_empty,
  input  entry_t q_data,
  output logic   pop,
  output logic   res_valid,
  input  logic   res_stall,
  output res_t   res_data
);

  back_state_t state, state_next;

  entry_t cur;
  logic [4:0] op_idx;
  logic [2:0] dig;
  logic signed [ACW-1:0] acc;

  logic signed [32:0] e1x, e1y, e1z, e2x, e2y, e2z, tx, ty, tz;
  logic signed [AW-1:0] px, py, pz, qx, qy, qz;
  logic signed [ACW-1:0] det, un, vn, tn;
  logic signed [46:0] hx, hy, hz;

  logic [DVW-1:0] rem, dsh;
  logic [30:0] quo;
  logic [4:0]  cnt;
  logic        ok;

  logic [30:0] best_distance;
  logic [11:0] best_surface;
  logic [15:0] best_triangle;
  logic        any_hit;

  mac_op_t op;
  logic signed [AW-1:0]  a_val;
  logic signed [BW-1:0]  b_val;
  logic [BW-1:0]         b_sh;
  logic signed [8:0]     dsg;
  logic signed [76:0]    pp;
  logic signed [ACW-1:0] pp_w, shifted, acc_base, acc_sum;
  logic                  op_done;

  logic        reject, sat;
  logic [ACW:0] uv_sum;
  logic        ge;
  logic        take;
  logic        out_free;

  assign op = mac_op(op_idx);

  always_comb begin
    unique case (op.a)
      A_E2X:   a_val = AW'(e2x);
      A_E2Y:   a_val = AW'(e2y);
      A_E2Z:   a_val = AW'(e2z);
      A_TX:    a_val = AW'(tx);
      A_TY:    a_val = AW'(ty);
      A_TZ:    a_val = AW'(tz);
      A_PX:    a_val = px;
      A_PY:    a_val = py;
      A_PZ:    a_val = pz;
      A_QX:    a_val = qx;
      A_QY:    a_val = qy;
      A_QZ:    a_val = qz;
      A_DIST:  a_val = AW'(best_distance);
      default: a_val = '0;
    endcase
  end

  always_comb begin
    unique case (op.b)
      B_DX:    b_val = BW'(cfg.ray_dir_x);
      B_DY:    b_val = BW'(cfg.ray_dir_y);
      B_DZ:    b_val = BW'(cfg.ray_dir_z);
      B_E1X:   b_val = BW'(e1x);
      B_E1Y:   b_val = BW'(e1y);
      B_E1Z:   b_val = BW'(e1z);
      B_TX:    b_val = BW'(tx);
      B_TY:    b_val = BW'(ty);
      B_TZ:    b_val = BW'(tz);
      B_E2X:   b_val = BW'(e2x);
      B_E2Y:   b_val = BW'(e2y);
      B_E2Z:   b_val = BW'(e2z);
      default: b_val = '0;
    endcase
  end

  // one 8-bit digit of the multiplier per cycle, top digit signed
  always_comb begin
    b_sh     = b_val >> {dig, 3'b000};
    dsg      = (dig == 3'd4) ? $signed({b_sh[7], b_sh[7:0]}) : $signed({1'b0, b_sh[7:0]});
    pp       = a_val * dsg;
    pp_w     = ACW'(pp);
    shifted  = pp_w <<< {dig, 3'b000};
    acc_base = (op.first && dig == 3'd0) ? '0 : acc;
    acc_sum  = op.neg ? acc_base - shifted : acc_base + shifted;
    op_done  = (dig == 3'd4);
  end

  always_comb begin
    uv_sum = {1'b0, un} + {1'b0, vn};
    reject = cur.skip || (det == '0) || (det < ACW'(cfg.det_threshold)) ||
             un[ACW-1] || (det < un) || vn[ACW-1] || ({1'b0, det} < uv_sum) ||
             tn[ACW-1];
    sat    = ({17'b0, tn, 14'b0} >= {det, 31'b0});
    ge     = (rem >= dsh);
    take   = ok && (quo > cfg.min_distance) && (!any_hit || quo < best_distance);
  end

  assign out_free = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (!q_empty) state_next = S_LOAD;
      S_LOAD:   state_next = S_MAC;
      S_MAC:    if (op_done && op_idx == OP_TEST_LAST) state_next = S_NORM;
      S_NORM:   state_next = S_TEST;
      S_TEST:   state_next = (reject || sat) ? S_UPDATE : S_DIV;
      S_DIV:    if (cnt == 5'd0) state_next = S_UPDATE;
      S_UPDATE: state_next = cur.item.last_triangle ? S_HIT : S_IDLE;
      S_HIT:    if (op_done && op_idx == OP_HIT_LAST) state_next = S_EMIT;
      S_EMIT:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == S_IDLE) && !q_empty;
  end

  function automatic logic signed [31:0] coord(input logic signed [31:0] org,
                                                input logic signed [46:0] h);
    logic signed [33:0] v;
    v = 34'(org) + 34'($signed(h[46:14]));
    if (v > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          cur <= q_data;
        end
      end
      S_LOAD: begin
        e1x    <= 33'(cur.item.v1_x) - 33'(cur.item.v0_x);
        e1y    <= 33'(cur.item.v1_y) - 33'(cur.item.v0_y);
        e1z    <= 33'(cur.item.v1_z) - 33'(cur.item.v0_z);
        e2x    <= 33'(cur.item.v2_x) - 33'(cur.item.v0_x);
        e2y    <= 33'(cur.item.v2_y) - 33'(cur.item.v0_y);
        e2z    <= 33'(cur.item.v2_z) - 33'(cur.item.v0_z);
        tx     <= 33'(cfg.ray_origin_x) - 33'(cur.item.v0_x);
        ty     <= 33'(cfg.ray_origin_y) - 33'(cur.item.v0_y);
        tz     <= 33'(cfg.ray_origin_z) - 33'(cur.item.v0_z);
        op_idx <= 5'd0;
        dig    <= 3'd0;
      end
      S_MAC, S_HIT: begin
        acc <= acc_sum;
        if (op_done) begin
          dig    <= 3'd0;
          op_idx <= op_idx + 5'd1;
          if (op.last) begin
            unique case (op.dest)
              D_PX:    px  <= acc_sum[AW-1:0];
              D_PY:    py  <= acc_sum[AW-1:0];
              D_PZ:    pz  <= acc_sum[AW-1:0];
              D_QX:    qx  <= acc_sum[AW-1:0];
              D_QY:    qy  <= acc_sum[AW-1:0];
              D_QZ:    qz  <= acc_sum[AW-1:0];
              D_DET:   det <= acc_sum;
              D_UN:    un  <= acc_sum;
              D_VN:    vn  <= acc_sum;
              D_TN:    tn  <= acc_sum;
              D_HX:    hx  <= acc_sum[46:0];
              D_HY:    hy  <= acc_sum[46:0];
              D_HZ:    hz  <= acc_sum[46:0];
              default: ;
            endcase
          end
        end else begin
          dig <= dig + 3'd1;
        end
      end
      S_NORM: begin
        if (det[ACW-1]) begin
          det <= -det;
          un  <= -un;
          vn  <= -vn;
          tn  <= -tn;
        end
      end
      S_TEST: begin
        ok  <= !reject;
        quo <= sat ? DIST_MAX : '0;
        rem <= DVW'({tn, 14'b0});
        dsh <= DVW'({det, 30'b0});
        cnt <= 5'd30;
      end
      S_DIV: begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quo <= {quo[29:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt - 5'd1;
      end
      S_UPDATE: begin
        op_idx <= OP_HIT_FIRST;
        dig    <= 3'd0;
      end
      default: ;
    endcase
  end

  // running nearest hit and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= DIST_MAX;
      best_surface  <= '0;
      best_triangle <= '0;
      any_hit       <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (state == S_UPDATE && take) begin
        best_distance <= quo;
        best_surface  <= cur.item.surface_id;
        best_triangle <= cur.item.triangle_id;
        any_hit       <= 1'b1;
      end
      if (state == S_EMIT && out_free) begin
        best_distance <= DIST_MAX;
        best_surface  <= '0;
        best_triangle <= '0;
        any_hit       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      res_data.hit_found    <= any_hit;
      res_data.hit_distance <= any_hit ? best_distance : DIST_MAX;
      res_data.hit_surface  <= any_hit ? best_surface : '0;
      res_data.hit_triangle <= any_hit ? best_triangle : '0;
      res_data.hit_x        <= any_hit ? coord(cfg.ray_origin_x, hx) : '0;
      res_data.hit_y        <= any_hit ? coord(cfg.ray_origin_y, hy) : '0;
      res_data.hit_z        <= any_hit ? coord(cfg.ray_origin_z, hz) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_mac_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (op_idx <= OP_TEST_LAST))
    else $error("test program ran past its last step");

  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_HIT) |-> (op_idx >= OP_HIT_FIRST && op_idx <= OP_HIT_LAST))
    else $error("hit point step out of range");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (!any_hit && res_valid))
    else $error("search not cleared on result");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_LOAD))
    else $error("queue popped outside idle");

endmodule
`default_nettype wire

// ----- src/closest_ray_triangle_hit_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// closest_ray_triangle_hit_core
// nearest ray/triangle hit search with an exact integer intersection test
// ----------------------------------------------------------------------------
// Each triangle transaction is tested against the configured ray and the
// nearest accepted hit is kept; a transaction marked last_triangle produces
// one result and clears the search. A triangle passes through the back end
// as a pop and a load step, 24 multiply-accumulate steps on the single
// shared 68x9-bit multiplier, a normalise and a test step, a restoring
// divide and an update step; one rejected by the test or with a saturated
// distance skips the divide. A last triangle then goes on to the hit point
// steps and the result hand-off. The front and a two-entry queue keep
// accepting while the back end works, until both the slot and queue are full.
module closest_ray_triangle_hit_core
  import crth_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tri_valid,
  output logic        tri_stall,
  input  tri_t        tri_data,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t   cfg;
  logic   push;
  entry_t push_data;
  logic   pop;
  entry_t pop_data;
  logic   q_full;
  logic   q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ray_origin_x  <= '0;
      cfg.ray_origin_y  <= '0;
      cfg.ray_origin_z  <= '0;
      cfg.ray_dir_x     <= 16'sd16384;
      cfg.ray_dir_y     <= '0;
      cfg.ray_dir_z     <= '0;
      cfg.det_threshold <= 32'd1;
      cfg.min_distance  <= 31'd6554;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:      cfg.ray_origin_x  <= cfg_data;
        REG_ORIGIN_Y:      cfg.ray_origin_y  <= cfg_data;
        REG_ORIGIN_Z:      cfg.ray_origin_z  <= cfg_data;
        REG_DIR_X:         cfg.ray_dir_x     <= cfg_data[15:0];
        REG_DIR_Y:         cfg.ray_dir_y     <= cfg_data[15:0];
        REG_DIR_Z:         cfg.ray_dir_z     <= cfg_data[15:0];
        REG_DET_THRESHOLD: cfg.det_threshold <= cfg_data;
        REG_MIN_DISTANCE:  cfg.min_distance  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  crth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tri_valid (tri_valid),
    .tri_stall (tri_stall),
    .tri_data  (tri_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  crth_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  crth_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule
`default_nettype wire
